// File: design/assert_macros.svh
// Assertion macros for the RTL of the FIR filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Invariant checked on every rising clock edge outside reset.
`define FCR_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("fir filter invariant violated");
// Implication checked on every rising clock edge outside reset.
`define FCR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fir filter implication violated");
`else
`define FCR_ASSERT(label, cond)
`define FCR_ASSERT_IMP(label, ante, cons)
`endif
`endif

// File: design/fir_crt_pkg.sv
// Constants and register codes for the complex FIR filter with real taps.
`default_nettype none
package fir_crt_pkg;

    // Tap format: signed Q1.15, four taps per 64-bit bank
    localparam int TAP_BITS      = 16;
    localparam int TAP_REGS      = 16;
    localparam int TAPS_PER_BANK = 4;
    localparam int NUM_BANKS     = 4;
    localparam int BANK_BITS     = 64;
    localparam int FRAC_BITS     = 15;
    localparam int TIU_BITS      = 5;
    localparam int CFG_IDX_BITS  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_BANK_0  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_BANK_3  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAPS_IN_USE = 3'd4;

    // Reset values
    localparam logic [BANK_BITS-1:0] BANK0_RESET = 64'd32767;
    localparam logic [BANK_BITS-1:0] BANK_RESET  = 64'd0;
    localparam logic [TIU_BITS-1:0]  TIU_RESET   = 5'd1;

    typedef logic [BANK_BITS-1:0] t_bank;
    typedef logic signed [TAP_BITS-1:0] t_tap;

endpackage
`default_nettype wire

// File: design/fir_filter_complex_real_taps_top.sv
// FIR filter, complex samples with real taps, bit-serial multiply-accumulate.
// Each sample is filtered over N taps, N = taps in use (1..16); a new sample
// is accepted only once the last result has loaded into the output register.
// Each tap takes a history memory read, then shift-add steps, one tap bit per
// cycle, MSB first; a stalled output register holds the sequencer in its output state.
// Reset (i_rst_n low, synchronous) clears the history valid bits, the slot
// pointer and the handshake state, and loads the tap registers' reset values.
`default_nettype none
`include "assert_macros.svh"
module fir_filter_complex_real_taps_top #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration write channel
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [fir_crt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [fir_crt_pkg::BANK_BITS-1:0]     i_cfg_data,
    // Sample input stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: sample_i, sample_q (low to high), zero padded to bytes
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // Result output stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata: out_i, out_q (low to high), zero padded to bytes
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
    // tuser: clipped
    output logic                                       m_axis_tuser
);
    import fir_crt_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int DATA_W    = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int SLOT_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W    = SB + TAP_BITS + 1;
    localparam int ACC_W     = SB + TAP_BITS + 4;
    localparam int RND_W     = ACC_W + 1;
    localparam int SHR_W     = RND_W - FRAC_BITS;
    localparam int TAP_IDX_W = $clog2(TAP_REGS);
    localparam int BIT_W     = $clog2(TAP_BITS);
    localparam logic [TIU_BITS-1:0] TAP_LIMIT =
        TIU_BITS'((MAX_TAPS < TAP_REGS) ? MAX_TAPS : TAP_REGS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TAPS - 1);
    localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'((64'sd1 <<< (SB-1)) - 64'sd1);
    localparam logic signed [SHR_W-1:0] SAT_LO = -SAT_HI - SHR_W'(1);
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd1 <<< (FRAC_BITS-1));

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_ACC, S_OUT} t_state;

    // Registers
    t_state                    r_state;
    t_bank                     r_tap_bank [NUM_BANKS];
    logic [TIU_BITS-1:0]       r_taps_in_use;
    logic [MAX_TAPS-1:0]       r_hist_vld;
    logic [2*SB-1:0]           r_hist_mem [MAX_TAPS];
    logic [SLOT_W-1:0]         r_newest;
    logic [SLOT_W-1:0]         r_rd_slot;
    logic [2*SB-1:0]           r_rd_word;
    logic                      r_rd_live;
    logic [TAP_IDX_W-1:0]      r_tap_idx;
    logic [TAP_BITS-1:0]       r_tap_sr;
    logic [BIT_W-1:0]          r_bit;
    logic signed [PROD_W-1:0]  r_prod_i, r_prod_q;
    logic signed [ACC_W-1:0]   r_acc_i, r_acc_q;
    logic signed [SB-1:0]      r_out_i, r_out_q;
    logic                      r_out_clip;
    logic                      r_out_vld;

    // Next values / combinational
    logic                      in_beat;
    logic [SLOT_W-1:0]         n_slot;
    logic [SLOT_W-1:0]         prev_rd_slot;
    logic [TIU_BITS-1:0]       n_eff;
    logic                      last_tap;
    t_tap                      tap_sel;
    logic signed [SB-1:0]      smp_i, smp_q;
    logic signed [PROD_W-1:0]  add_i, add_q;
    logic signed [PROD_W-1:0]  n_prod_i, n_prod_q;
    logic signed [RND_W-1:0]   rnd_i, rnd_q;
    logic signed [SHR_W-1:0]   shr_i, shr_q;
    logic signed [SB-1:0]      sat_i, sat_q;
    logic                      clip_i, clip_q;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = DATA_W'({r_out_q, r_out_i});
    assign m_axis_tuser  = r_out_clip;

    // Ring pointer arithmetic, modulo the history depth
    assign n_slot       = (r_newest == SLOT_LAST) ? '0 : r_newest + SLOT_W'(1);
    assign prev_rd_slot = (r_rd_slot == '0) ? SLOT_LAST : r_rd_slot - SLOT_W'(1);

    // Effective tap count: at least one, at most the tap limit
    always_comb begin
        if (r_taps_in_use == '0) begin
            n_eff = TIU_BITS'(1);
        end else if (r_taps_in_use > TAP_LIMIT) begin
            n_eff = TAP_LIMIT;
        end else begin
            n_eff = r_taps_in_use;
        end
    end
    assign last_tap = ((TIU_BITS'(r_tap_idx) + TIU_BITS'(1)) == n_eff);

    // Tap select from the banks
    assign tap_sel = r_tap_bank[r_tap_idx[TAP_IDX_W-1:2]][r_tap_idx[1:0]*TAP_BITS +: TAP_BITS];

    // Horner step: MSB carries negative weight
    assign smp_i = r_rd_live ? r_rd_word[SB-1:0]    : '0;
    assign smp_q = r_rd_live ? r_rd_word[2*SB-1:SB] : '0;
    always_comb begin
        add_i = '0;
        add_q = '0;
        if (r_tap_sr[TAP_BITS-1]) begin
            if (r_bit == '0) begin
                add_i = -PROD_W'(smp_i);
                add_q = -PROD_W'(smp_q);
            end else begin
                add_i = PROD_W'(smp_i);
                add_q = PROD_W'(smp_q);
            end
        end
    end
    assign n_prod_i = (r_prod_i <<< 1) + add_i;
    assign n_prod_q = (r_prod_q <<< 1) + add_q;

    // Round half up, drop fraction bits, saturate
    assign rnd_i = RND_W'(r_acc_i) + RND_HALF;
    assign rnd_q = RND_W'(r_acc_q) + RND_HALF;
    assign shr_i = SHR_W'(rnd_i >>> FRAC_BITS);
    assign shr_q = SHR_W'(rnd_q >>> FRAC_BITS);
    always_comb begin
        clip_i = 1'b0;
        clip_q = 1'b0;
        sat_i  = SB'(shr_i);
        sat_q  = SB'(shr_q);
        if (shr_i > SAT_HI) begin
            sat_i  = SB'(SAT_HI);
            clip_i = 1'b1;
        end else if (shr_i < SAT_LO) begin
            sat_i  = SB'(SAT_LO);
            clip_i = 1'b1;
        end
        if (shr_q > SAT_HI) begin
            sat_q  = SB'(SAT_HI);
            clip_q = 1'b1;
        end else if (shr_q < SAT_LO) begin
            sat_q  = SB'(SAT_LO);
            clip_q = 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_bank[0] <= BANK0_RESET;
            for (int b = 1; b < NUM_BANKS; b++) begin
                r_tap_bank[b] <= BANK_RESET;
            end
            r_taps_in_use <= TIU_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index) inside
                [CFG_TAP_BANK_0:CFG_TAP_BANK_3]: r_tap_bank[i_cfg_index[1:0]] <= i_cfg_data;
                CFG_TAPS_IN_USE:                 r_taps_in_use <= i_cfg_data[TIU_BITS-1:0];
                default: ;
            endcase
        end
    end

    // History memory: one write per accepted beat, one registered read per tap
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_hist_mem[n_slot] <= s_axis_tdata[2*SB-1:0];
        end
        if (r_state == S_READ) begin
            r_rd_word <= r_hist_mem[r_rd_slot];
        end
    end

    // Control sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hist_vld <= '0;
            r_newest   <= '0;
            r_out_vld  <= 1'b0;
            r_bit      <= '0;
        end else begin
            // Output valid: set when a result loads, cleared by a taken beat
            if (r_state == S_OUT && (!r_out_vld || m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_newest           <= n_slot;
                        r_rd_slot          <= n_slot;
                        r_hist_vld[n_slot] <= 1'b1;
                        r_tap_idx          <= '0;
                        r_prod_i           <= '0;
                        r_prod_q           <= '0;
                        r_acc_i            <= '0;
                        r_acc_q            <= '0;
                        r_state            <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_live <= r_hist_vld[r_rd_slot];
                    r_rd_slot <= prev_rd_slot;
                    r_tap_sr  <= tap_sel;
                    r_acc_i   <= r_acc_i + ACC_W'(r_prod_i);
                    r_acc_q   <= r_acc_q + ACC_W'(r_prod_q);
                    r_prod_i  <= '0;
                    r_prod_q  <= '0;
                    r_bit     <= '0;
                    r_state   <= S_MAC;
                end
                S_MAC: begin
                    r_prod_i <= n_prod_i;
                    r_prod_q <= n_prod_q;
                    r_tap_sr <= r_tap_sr << 1;
                    r_bit    <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(TAP_BITS - 1)) begin
                        if (last_tap) begin
                            r_state <= S_ACC;
                        end else begin
                            r_tap_idx <= r_tap_idx + TAP_IDX_W'(1);
                            r_state   <= S_READ;
                        end
                    end
                end
                S_ACC: begin
                    r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
                    r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_i    <= sat_i;
                        r_out_q    <= sat_q;
                        r_out_clip <= clip_i || clip_q;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    `FCR_ASSERT(a_tap_in_range, (r_state != S_MAC) || (TIU_BITS'(r_tap_idx) < n_eff))
    `FCR_ASSERT_IMP(a_read_starts_tap, r_state == S_READ, r_bit == '0)
    `FCR_ASSERT_IMP(a_beat_starts_read, in_beat, ##1 r_state == S_READ)
    `FCR_ASSERT_IMP(a_result_from_out, $rose(r_out_vld), $past(r_state == S_OUT))
    `FCR_ASSERT_IMP(a_newest_valid, r_state != S_IDLE, r_hist_vld[r_newest])

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the complex-sample FIR filter with real taps.
`default_nettype none
module tb;
    import fir_crt_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int HIST_DEPTH  = 16;
    localparam int DATA_W      = ((2*SAMPLE_BITS+7)/8)*8;
    // Worst-case accept-to-result time at sixteen taps, plus margin
    localparam int DRAIN_CYCLES = 17*TAP_REGS + 8;
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_ITEMS  = 148;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample out_i;
        t_sample out_q;
        logic    clipped;
    } t_filt_result;

    // Clock, reset and block ports
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index   = '0;
    logic [BANK_BITS-1:0]    i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [DATA_W-1:0]       s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [DATA_W-1:0]       m_axis_tdata;
    logic                    m_axis_tuser;

    // Filter state as the testbench tracks it
    t_bank             coef_bank [NUM_BANKS];
    logic [TIU_BITS-1:0] tap_count_reg;
    t_sample           line_i [HIST_DEPTH];
    t_sample           line_q [HIST_DEPTH];
    int                newest;

    t_filt_result pending_results[$];
    bit           idle_en = 1'b1;
    int           mismatches = 0;
    int           samples_sent = 0;
    int           results_seen = 0;
    int           clip_seen = 0;
    int           reg_writes = 0;

    fir_filter_complex_real_taps_top #(
        .MAX_TAPS   (HIST_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Reset-time filter state
    function automatic void clear_filter_state();
        coef_bank[0]  = BANK0_RESET;
        coef_bank[1]  = BANK_RESET;
        coef_bank[2]  = BANK_RESET;
        coef_bank[3]  = BANK_RESET;
        tap_count_reg = TIU_RESET;
        newest        = 0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            line_i[k] = '0;
            line_q[k] = '0;
        end
    endfunction

    function automatic t_sample clamp_part(longint acc, ref bit clip);
        longint r;
        r = (acc + 64'sd16384) >>> FRAC_BITS;   // round half up, floor shift
        if (r > 64'sd32767) begin
            clip = 1'b1;
            return 16'sh7FFF;
        end
        if (r < -64'sd32768) begin
            clip = 1'b1;
            return 16'sh8000;
        end
        return t_sample'(r[SAMPLE_BITS-1:0]);
    endfunction

    // Push one sample into the delay line and compute the filter output
    function automatic t_filt_result filter_sample(t_sample si, t_sample sq);
        t_filt_result res;
        int           n;
        int           slot;
        t_tap         tap;
        longint       acc_i;
        longint       acc_q;
        bit           clip;
        n     = int'(tap_count_reg);
        acc_i = 0;
        acc_q = 0;
        clip  = 1'b0;
        if (n < 1) n = 1;
        if (n > TAP_REGS) n = TAP_REGS;
        if (n > HIST_DEPTH) n = HIST_DEPTH;
        newest         = (newest + 1) % HIST_DEPTH;
        line_i[newest] = si;
        line_q[newest] = sq;
        slot = newest;
        for (int m = 0; m < n; m++) begin
            tap   = t_tap'(coef_bank[m >> 2][(m & 3)*TAP_BITS +: TAP_BITS]);
            acc_i += longint'(tap) * longint'(line_i[slot]);
            acc_q += longint'(tap) * longint'(line_q[slot]);
            slot  = (slot + HIST_DEPTH - 1) % HIST_DEPTH;
        end
        res.out_i   = clamp_part(acc_i, clip);
        res.out_q   = clamp_part(acc_q, clip);
        res.clipped = clip;
        return res;
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= idle_en ? ($urandom_range(0, 99) >= 38) : 1'b1;
    end

    // Result checker
    always @(posedge i_clk) begin
        t_filt_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser) clip_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result i=%0d q=%0d clipped=%0b", $time,
                         $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                         m_axis_tuser);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== exp_res.out_i) begin
                    mismatches++;
                    $display("%0t: out_i expected %0d actual %0d", $time,
                             exp_res.out_i, $signed(m_axis_tdata[15:0]));
                end
                if (m_axis_tdata[31:16] !== exp_res.out_q) begin
                    mismatches++;
                    $display("%0t: out_q expected %0d actual %0d", $time,
                             exp_res.out_q, $signed(m_axis_tdata[31:16]));
                end
                if (m_axis_tuser !== exp_res.clipped) begin
                    mismatches++;
                    $display("%0t: clipped expected %0b actual %0b", $time,
                             exp_res.clipped, m_axis_tuser);
                end
            end
        end
    end

    // One register write; valid stays high when another write follows
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [BANK_BITS-1:0] val,
                             bit more = 1'b0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (!more) i_cfg_valid <= 1'b0;
        reg_writes++;
        if (idx <= CFG_TAP_BANK_3)
            coef_bank[idx[1:0]] = val;
        else if (idx == CFG_TAPS_IN_USE)
            tap_count_reg = val[TIU_BITS-1:0];
    endtask

    // One sample beat, with an optional random gap ahead of it
    task automatic send_sample(t_sample si, t_sample sq);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 99) < 38)
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 300) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sq, si};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(filter_sample(si, sq));
        samples_sent++;
    endtask

    // Stop sending and let the block run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample v;
        v = t_sample'($urandom);
        case ($urandom_range(0, 3))
            1: v = v >>> $urandom_range(4, 14);
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sh0000;
                    default: v = 16'shFFFF;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [BANK_BITS-1:0] rand_bank(int kind);
        logic [BANK_BITS-1:0] b;
        t_tap                 t;
        for (int k = 0; k < TAPS_PER_BANK; k++) begin
            t = t_tap'($urandom);
            if (kind == 1) t = t >>> $urandom_range(2, 8);
            else if (kind == 2) t = t >>> 12;
            b[k*TAP_BITS +: TAP_BITS] = t;
        end
        return b;
    endfunction

    // Reset values: single tap just under one
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh0000, 16'shFFFF);
        send_sample(16'shFFFF, 16'sh0000);
        settle();
    endtask

    // Half-way products round toward plus infinity
    task automatic test_rounding();
        write_reg(CFG_TAP_BANK_0, 64'h0000_0000_0000_4000);
        send_sample(16'sd1, -16'sd1);
        send_sample(16'sd3, -16'sd3);
        send_sample(16'sd2, -16'sd2);
        settle();
    endtask

    // Overflow on both signs, each part on its own
    task automatic test_saturation();
        write_reg(CFG_TAP_BANK_0, 64'h0000_0000_0000_8000);
        send_sample(16'sh8000, 16'sh0000);
        send_sample(16'sh7FFF, 16'sh8000);
        settle();
        write_reg(CFG_TAP_BANK_0, 64'h0000_0000_7FFF_7FFF, 1'b1);
        write_reg(CFG_TAPS_IN_USE, 64'd2);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF);
        settle();
    endtask

    // Tap count of zero, sixteen and beyond; extreme tap banks
    task automatic test_tap_count_limits();
        write_reg(CFG_TAP_BANK_0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        write_reg(CFG_TAP_BANK_0 + 3'd1, 64'h8000_8000_8000_8000, 1'b1);
        write_reg(CFG_TAP_BANK_0 + 3'd2, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1);
        write_reg(CFG_TAP_BANK_3, 64'h0000_0000_0000_0000, 1'b1);
        write_reg(CFG_TAPS_IN_USE, {$urandom, $urandom} & ~64'h1F);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh1234, -16'sh0F0F);
        settle();
        write_reg(CFG_TAPS_IN_USE, 64'd16);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        settle();
        write_reg(CFG_TAP_BANK_3, {$urandom, $urandom}, 1'b1);
        write_reg(CFG_TAPS_IN_USE, 64'd17);
        send_sample(16'sh4000, -16'sh4000);
        send_sample(16'sh0001, 16'sh0000);
        settle();
        write_reg(CFG_TAPS_IN_USE, 64'd31);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        settle();
    endtask

    // Writes to unused indexes leave every register alone
    task automatic test_bad_index();
        write_reg(CFG_TAPS_IN_USE + 3'd1, {$urandom, $urandom}, 1'b1);
        write_reg(CFG_TAPS_IN_USE + 3'd2, {$urandom, $urandom}, 1'b1);
        write_reg(CFG_TAPS_IN_USE + 3'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(16'sh2345, -16'sh2345);
        send_sample(-16'sh7000, 16'sh6000);
        send_sample(16'sh0100, 16'sh0000);
        settle();
    endtask

    // Random coefficients and tap counts, random sample streams
    task automatic test_random_stream(int phase);
        int                   kind;
        int                   n;
        logic [BANK_BITS-1:0] raw;
        kind = $urandom_range(0, 2);
        if (phase == 0 || $urandom_range(0, 3) == 0) n = TAP_REGS;
        else if (phase == 1) n = 1;
        else n = $urandom_range(1, 6);
        raw = 64'(n);
        if ($urandom_range(0, 5) == 0)
            raw = (n == 1) ? 64'd0 : 64'(17 + $urandom_range(0, 14));
        idle_en = !(phase == 2 || phase == 3);
        for (int b = 0; b < NUM_BANKS; b++)
            write_reg(CFG_TAP_BANK_0 + 3'(b), rand_bank(kind), 1'b1);
        write_reg(CFG_TAPS_IN_USE, raw);
        for (int k = 0; k < PHASE_ITEMS; k++)
            send_sample(rand_sample(), rand_sample());
        settle();
        idle_en = 1'b1;
    endtask

    // Test sequence
    initial begin
        clear_filter_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_rounding();
        test_saturation();
        test_tap_count_limits();
        test_bad_index();
        for (int p = 0; p < RAND_PHASES; p++)
            test_random_stream(p);
        settle();
        $display("Covered %0d samples, %0d results (%0d saturated), %0d register writes",
                 samples_sent, results_seen, clip_seen, reg_writes);
        $display("Tap counts 0..31 raw, unused register indexes, rounding and clipping");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
